### rtl/sorted_list_merge_macros.svh
// ----------------------------------------------------------------------------
// Sorted list merge: assertion macros
// Concurrent check wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_MERGE_MACROS_SVH
`define SORTED_LIST_MERGE_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define SLM_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("sorted_list_merge: check failed");

// Check that a consequent holds in the cycle after an antecedent.
`define SLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorted_list_merge: check failed");

`else

`define SLM_ASSERT(lbl, clk, rstn, cond)
`define SLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list merge package
// Field widths, action codes and the controller state type.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } slm_state_e;

endpackage

### rtl/slm_if.sv
// ----------------------------------------------------------------------------
// Sorted list merge channels
// Valid/ready interfaces for the command input and the merged result output.
// ----------------------------------------------------------------------------
interface slm_in_if;
  import slm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface slm_out_if;
  import slm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  merged_value;
  logic                       last;
  logic                       dropped;

  modport source (output valid, merged_value, last, dropped, input ready);
  modport sink   (input valid, merged_value, last, dropped, output ready);
endinterface

### rtl/sorted_list_merge.sv
// ----------------------------------------------------------------------------
// Sorted list merge
// Loads two ascending lists and streams out their ascending merge.
// ----------------------------------------------------------------------------
// Input beats carry an action and a value: load A and load B append the
// value to list A or list B (one beat per cycle while idle); start streams
// the merge out on the result channel. A load into a full list is dropped
// and flagged on the dropped bit of the last result of the next merge.
// On equal heads, B goes first. Start with both lists empty gives nothing.
// The start beat moves the controller to merge, and the first result is
// registered in the merge state; after that one result per cycle while the
// receiver takes them. The rate is set by the two list RAMs: each holds its
// head read ahead, addressed by the next index. A receiver stall holds the
// result register and the indexes, and the RAMs reread the same heads. The
// input reopens once the last result is registered. Reset clears the counts,
// the overflow flag and the controller; list contents stay undefined until
// loaded.
// ----------------------------------------------------------------------------
`include "sorted_list_merge_macros.svh"

module sorted_list_merge #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slm_in_if.sink    in_i,
  slm_out_if.source out_o
);
  import slm_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  slm_state_e state_q, state_d;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic          ovf_q, ovf_d;

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q;
  logic                      out_drop_q;

  logic [DATA_WIDTH-1:0] head_a, head_b, head_pick, load_word;

  logic in_fire, do_load_a, do_load_b, do_start, start_empty;
  logic we_a, we_b;
  logic emit, take_a, pick_last;

  // ---------------- handshake and command decode ----------------
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    in_fire    = in_i.valid && in_i.ready;
    do_load_a  = 1'b0;
    do_load_b  = 1'b0;
    do_start   = 1'b0;
    case (in_i.action)
      ACT_LOAD_A: do_load_a = in_fire;
      ACT_LOAD_B: do_load_b = in_fire;
      ACT_START:  do_start  = in_fire;
      default: ;
    endcase
    start_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
  end

  assign we_a      = do_load_a && (cnt_a_q < DEPTH_C);
  assign we_b      = do_load_b && (cnt_b_q < DEPTH_C);
  assign load_word = DATA_WIDTH'(in_i.value);

  // ---------------- merge pick ----------------
  always_comb begin
    emit   = (state_q == ST_MERGE) && (!out_valid_q || out_o.ready);
    take_a = (idx_a_q < cnt_a_q) &&
             ((idx_b_q >= cnt_b_q) || ($signed(head_a) < $signed(head_b)));
    if (take_a) begin
      pick_last = (idx_a_q + 1'b1 == cnt_a_q) && (idx_b_q == cnt_b_q);
      head_pick = head_a;
    end else begin
      pick_last = (idx_b_q + 1'b1 == cnt_b_q) && (idx_a_q == cnt_a_q);
      head_pick = head_b;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (do_start && !start_empty) state_d = ST_MERGE;
      ST_MERGE: if (emit && pick_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------- counters, indexes, flag ----------------
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    idx_a_d = idx_a_q;
    idx_b_d = idx_b_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (we_a) cnt_a_d = cnt_a_q + 1'b1;
        if (we_b) cnt_b_d = cnt_b_q + 1'b1;
        if ((do_load_a && !we_a) || (do_load_b && !we_b)) ovf_d = 1'b1;
        if (do_start && start_empty) ovf_d = 1'b0;
      end
      ST_MERGE: begin
        if (emit) begin
          if (pick_last) begin
            // run done: clear for the next load phase
            cnt_a_d = '0;
            cnt_b_d = '0;
            idx_a_d = '0;
            idx_b_d = '0;
            ovf_d   = 1'b0;
          end else if (take_a) begin
            idx_a_d = idx_a_q + 1'b1;
          end else begin
            idx_b_d = idx_b_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      idx_a_q <= idx_a_d;
      idx_b_q <= idx_b_d;
      ovf_q   <= ovf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= VALUE_W'($signed(head_pick));
      out_last_q  <= pick_last;
      out_drop_q  <= pick_last && ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_value_q;
  assign out_o.last         = out_last_q;
  assign out_o.dropped      = out_drop_q;

  // ---------------- list RAMs ----------------
  // Read at the next index so the head for the current index is ready.
  // Loads only happen while idle, so a write never meets a merge read.
  slm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (load_word),
    .raddr_i (idx_a_d[AW-1:0]),
    .rdata_o (head_a)
  );

  slm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (load_word),
    .raddr_i (idx_b_d[AW-1:0]),
    .rdata_o (head_b)
  );

  // ---------------- checks ----------------
  `SLM_ASSERT(a_idx_in_range, clk_i, rst_ni,
    (idx_a_q <= cnt_a_q) && (idx_b_q <= cnt_b_q) && (cnt_a_q <= DEPTH_C) && (cnt_b_q <= DEPTH_C))
  `SLM_ASSERT(a_merge_has_work, clk_i, rst_ni,
    (state_q != ST_MERGE) || (idx_a_q < cnt_a_q) || (idx_b_q < cnt_b_q))
  `SLM_ASSERT(a_idle_idx_zero, clk_i, rst_ni,
    (state_q != ST_IDLE) || ((idx_a_q == '0) && (idx_b_q == '0)))
  `SLM_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, emit && pick_last,
    (state_q == ST_IDLE) && (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q && out_valid_q)

endmodule

### rtl/slm_ram.sv
// ----------------------------------------------------------------------------
// Sorted list merge RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Sorted list merge testbench
// Loads lists A and B over the command channel, starts merges, and checks
// every merged beat against a shadow model of the two lists, under random
// gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module testbench;
  import slm_pkg::*;

  localparam int unsigned LIST_DEPTH  = 32;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int          RANDOM_LOADS = 340;
  localparam int          STALL_LIMIT  = 1000;

  // The action code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [VALUE_W-1:0] WORD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] WORD_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
    logic                hold;   // wait for every pending merge beat first
    logic                calm;   // no gap after this beat
  } cmd_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               dropped;
  } merge_word_t;

  logic clk_i;
  logic rst_ni;

  slm_in_if  cmd_if ();
  slm_out_if res_if ();

  sorted_list_merge #(
    .LIST_DEPTH(LIST_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Shadow copy of the block's lists and flags.
  logic signed [VALUE_W-1:0] shadow_a [LIST_DEPTH];
  logic signed [VALUE_W-1:0] shadow_b [LIST_DEPTH];
  int                        fill_a;
  int                        fill_b;
  logic                      lost_load;

  cmd_item_t   pending_cmds [$];
  merge_word_t merge_due [$];

  cmd_item_t next_cmd;
  int        send_gap;
  int        recv_stall;
  bit        recv_calm;
  int        accepted_cmds;
  int        total_cmds;
  int        load_count;
  int        mismatches;
  int        quiet_cycles;

  task automatic merge_predict(input logic [ACTION_W-1:0] act,
                               input logic [VALUE_W-1:0] val);
    int          ia;
    int          ib;
    int          total;
    merge_word_t w;
    ia = 0;
    ib = 0;
    case (act)
      ACT_LOAD_A: begin
        if (fill_a < LIST_DEPTH) begin
          shadow_a[fill_a] = val;
          fill_a++;
        end else begin
          lost_load = 1'b1;
        end
      end
      ACT_LOAD_B: begin
        if (fill_b < LIST_DEPTH) begin
          shadow_b[fill_b] = val;
          fill_b++;
        end else begin
          lost_load = 1'b1;
        end
      end
      ACT_START: begin
        total = fill_a + fill_b;
        for (int n = 0; n < total; n++) begin
          // take B on equal heads
          if (ia < fill_a && (ib >= fill_b || shadow_a[ia] < shadow_b[ib])) begin
            w.value = shadow_a[ia];
            ia++;
          end else begin
            w.value = shadow_b[ib];
            ib++;
          end
          w.last    = (n == total - 1);
          w.dropped = w.last && lost_load;
          merge_due.push_back(w);
        end
        fill_a    = 0;
        fill_b    = 0;
        lost_load = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_cmd(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                          input bit hold, input bit calm);
    cmd_item_t c;
    c.action = act;
    c.value  = val;
    c.hold   = hold;
    c.calm   = calm;
    pending_cmds.push_back(c);
    if (act != ACT_UNUSED) load_count++;
  endtask

  function automatic logic [VALUE_W-1:0] draw_word(input int mode);
    logic [VALUE_W-1:0] w;
    case (mode)
      1: w = $urandom_range(0, 6) - 3;   // narrow range: many equal heads
      2: begin
        case ($urandom_range(0, 4))
          0: w = WORD_MIN;
          1: w = WORD_MAX;
          2: w = '0;
          3: w = '1;
          default: w = $urandom;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic int draw_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(30, 35);
    return $urandom_range(0, 6);
  endfunction

  // Queue loads for both lists, interleaved at random, then a start.
  task automatic queue_merge_run(input int na, input int nb, input int mode,
                                 input bit sorted, input bit hold, input bit calm);
    logic signed [VALUE_W-1:0] va [$];
    logic signed [VALUE_W-1:0] vb [$];
    bit                        first_hold;
    first_hold = hold;
    for (int i = 0; i < na; i++) va.push_back(draw_word(mode));
    for (int i = 0; i < nb; i++) vb.push_back(draw_word(mode));
    if (sorted) begin
      va.sort();
      vb.sort();
    end
    while (va.size() + vb.size() > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        push_cmd(ACT_UNUSED, $urandom, first_hold, calm);
        first_hold = 1'b0;
      end
      if (vb.size() == 0 || (va.size() > 0 && $urandom_range(0, 1) == 1)) begin
        push_cmd(ACT_LOAD_A, va.pop_front(), first_hold, calm);
      end else begin
        push_cmd(ACT_LOAD_B, vb.pop_front(), first_hold, calm);
      end
      first_hold = 1'b0;
    end
    push_cmd(ACT_START, $urandom, first_hold, calm);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Command driver: present one beat at a time, with a drawn gap after each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid  <= 1'b0;
      cmd_if.action <= ACT_LOAD_A;
      cmd_if.value  <= '0;
      send_gap = 0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (cmd_if.valid) begin
        merge_predict(cmd_if.action, cmd_if.value);
        accepted_cmds++;
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].hold && merge_due.size() != 0)) begin
        next_cmd = pending_cmds.pop_front();
        cmd_if.valid  <= 1'b1;
        cmd_if.action <= next_cmd.action;
        cmd_if.value  <= next_cmd.value;
        send_gap = next_cmd.calm ? 0 : $urandom_range(0, 4);
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: check each merged beat, then draw the stall for the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall = 0;
      recv_calm  = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (merge_due.size() == 0) begin
          $error("unexpected merged beat: merged_value %0d", res_if.merged_value);
          mismatches++;
        end else begin
          merge_word_t want;
          want = merge_due.pop_front();
          if (res_if.merged_value !== want.value) begin
            $error("merged_value: expected %0d, got %0d",
                   $signed(want.value), res_if.merged_value);
            mismatches++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_if.last);
            mismatches++;
          end
          if (res_if.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, res_if.dropped);
            mismatches++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_calm = ~recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 4);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      res_if.ready <= (recv_stall == 0);
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int  run_no;
    int  kind;
    bit  calm;
    bit  hold;
    rst_ni        = 1'b0;
    fill_a        = 0;
    fill_b        = 0;
    lost_load     = 1'b0;
    accepted_cmds = 0;
    load_count    = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    run_no        = 0;

    // Start with both lists empty: nothing comes out.
    push_cmd(ACT_START, '1, 1'b0, 1'b0);
    push_cmd(ACT_UNUSED, '1, 1'b0, 1'b0);
    push_cmd(ACT_UNUSED, '0, 1'b0, 1'b0);
    // Extremes on both lists, with equal heads at min, zero and max.
    push_cmd(ACT_LOAD_A, WORD_MIN, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_B, WORD_MIN, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_A, '1, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_B, '0, 1'b0, 1'b0);
    push_cmd(ACT_UNUSED, 32'h5a5a_a5a5, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_A, '0, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_B, 32'd5, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_A, WORD_MAX, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_B, WORD_MAX, 1'b0, 1'b0);
    push_cmd(ACT_START, '0, 1'b0, 1'b0);
    // Only list A, loaded out of order.
    push_cmd(ACT_LOAD_A, 32'd7, 1'b0, 1'b0);
    push_cmd(ACT_LOAD_A, 32'd3, 1'b0, 1'b0);
    push_cmd(ACT_START, '0, 1'b0, 1'b0);
    // Only list B, a single element; hold until the merges above drain.
    push_cmd(ACT_LOAD_B, 32'd42, 1'b1, 1'b0);
    push_cmd(ACT_START, '0, 1'b0, 1'b0);

    while (load_count < RANDOM_LOADS + 15) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 4) == 0);
      hold = ($urandom_range(0, 14) == 0);
      if (run_no == 0) begin
        // Fill A past capacity and B to capacity: the longest merge.
        queue_merge_run(LIST_DEPTH + 2, LIST_DEPTH, 0, 1'b1, 1'b1, 1'b0);
      end else if (kind < 7) begin
        queue_merge_run(draw_len(), draw_len(), $urandom_range(0, 2), 1'b1, hold, calm);
      end else if (kind < 9) begin
        queue_merge_run(draw_len(), draw_len(), $urandom_range(0, 2), 1'b0, hold, calm);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          push_cmd(ACTION_W'($urandom_range(0, 3)), $urandom, hold, calm);
          hold = 1'b0;
        end
      end
      run_no++;
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cmds != total_cmds || merge_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/slm_pkg.sv
rtl/slm_if.sv
rtl/slm_ram.sv
rtl/sorted_list_merge.sv
tb/testbench.sv
